// File: hdl/prcs_pkg.sv
// Shared widths, register map, state type and defaults of the resistor count solver.
package prcs_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int OFS_W      = 4;
    localparam int A_W        = SAMPLE_W + 1;
    localparam int REST_W     = SAMPLE_W;
    localparam int SCALE_W    = 24;
    localparam int DIVR_W     = 16;
    localparam int COEF_W     = 16;
    localparam int STEP_W     = 15;
    localparam int COUNT_W    = 4;

    localparam int DEN_W      = DIVR_W + A_W;
    localparam int NUM_W      = SCALE_W + REST_W + 1;
    localparam int CAND_W     = NUM_W + 2;
    localparam int N_W        = COEF_W + CAND_W + 1;
    localparam int DIV_W      = N_W - 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int MA_W       = COEF_W + 1;
    localparam int MB_W       = N_W;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int LIM_W      = STEP_W + 2;

    localparam int FULL_SCALE = 1023;

    localparam int MAX_TRIES_DEF   = 19;
    localparam int COUNT_LIMIT_DEF = 10;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(1);
    localparam logic [DIVR_W-1:0]  DIVR_RST   = DIVR_W'(1);
    localparam logic [COEF_W-1:0]  COEF_RST   = '0;
    localparam logic [STEP_W-1:0]  STEP_RST   = STEP_W'(1);
    localparam logic [OFS_W-1:0]   OFS_RST    = OFS_W'(1);

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [COUNT_W-1:0]  t_count;

    typedef enum logic [2:0] {
        REG_SCALE,
        REG_DIVISOR,
        REG_COEF1,
        REG_COEF2,
        REG_STEP1,
        REG_STEP2,
        REG_OFFSET
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEN,
        S_NUM,
        S_GSTART,
        S_GDIV,
        S_MUL1,
        S_MUL2,
        S_EVAL,
        S_KDIV,
        S_KMUL,
        S_KCHK,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

// File: hdl/prcs_if.sv
// Valid/ready channel interfaces for the sample input and the count result.
interface prcs_in_if;
    import prcs_pkg::*;

    logic    valid;
    logic    ready;
    t_sample adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface prcs_out_if;
    import prcs_pkg::*;

    logic   valid;
    logic   ready;
    t_count count_first;
    t_count count_second;

    modport source (output valid, output count_first, output count_second, input ready);
    modport sink   (input valid, input count_first, input count_second, output ready);
endinterface

// File: hdl/prcs_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the solver.
module prcs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [prcs_pkg::DIV_W-1:0]    i_dividend,
    input  logic [prcs_pkg::DEN_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [prcs_pkg::DIV_W-1:0]    o_quotient,
    output logic [prcs_pkg::DEN_W-1:0]    o_remainder
);
    import prcs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_dvs;

    logic [DEN_W:0]       trial;
    logic                 fits;
    logic [DEN_W:0]       diff;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract where it fits
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: hdl/parallel_resistor_count_solver.sv
// Top level: config registers, shared multiplier, candidate sequencer and result register.
//
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+------------------------------------
//  i_in     | in  | valid / ready   | adc_sample[9:0]
//  o_out    | out | valid / ready   | count_first[3:0], count_second[3:0]
//  apb      | in  | psel/penable    | paddr[4:2] register, pwdata, prdata
//
//  One sample at a time; ready is high only while the sequencer is idle.
//  The rounded quotient comes first, then up to MAX_TRIES candidates are tried;
//  the quotient and each candidate lift use the 53-step shared divider. The
//  result register holds a word until taken, and a new sample is accepted
//  meanwhile. Reset is synchronous; it clears the sequencer, the result valid
//  and loads the register defaults.
module parallel_resistor_count_solver #(
    parameter int MAX_TRIES   = prcs_pkg::MAX_TRIES_DEF,
    parameter int COUNT_LIMIT = prcs_pkg::COUNT_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    prcs_in_if.sink                       i_in,
    prcs_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [prcs_pkg::DATA_W-1:0]   pwdata,
    output logic [prcs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import prcs_pkg::*;

    localparam int TRY_W = $clog2(MAX_TRIES + 1);

    // configuration registers
    logic [SCALE_W-1:0]        r_scale;
    logic [DIVR_W-1:0]         r_divisor;
    logic signed [COEF_W-1:0]  r_coef1;
    logic signed [COEF_W-1:0]  r_coef2;
    logic [STEP_W-1:0]         r_step1;
    logic [STEP_W-1:0]         r_step2;
    logic [OFS_W-1:0]          r_offset;

    // sequencer and datapath
    t_state                    r_state;
    t_state                    n_state;
    logic [A_W-1:0]            r_a;
    logic [REST_W-1:0]         r_rest;
    logic [DEN_W-1:0]          r_den;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CAND_W-1:0]  r_cand;
    logic [TRY_W-1:0]          r_try;
    logic signed [N_W-1:0]     r_n1;
    logic signed [N_W-1:0]     r_n2;
    logic                      r_swap;
    logic [DIV_W-1:0]          r_k;
    logic [STEP_W-1:0]         r_negc;
    logic signed [LIM_W-1:0]   r_lim;
    t_count                    r_res1;
    t_count                    r_res2;

    logic                      r_out_valid;
    t_count                    r_out_first;
    t_count                    r_out_second;

    // shared multiplier
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // divider hookup
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DEN_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quo;
    logic [DEN_W-1:0]          div_rem;

    // sequencer helpers
    logic                      in_fire;
    logic                      out_free;
    logic [A_W-1:0]            a_in;
    logic [NUM_W-1:0]          g_num;
    logic                      n1_neg;
    logic                      n2_neg;
    logic                      e_swap;
    logic signed [N_W-1:0]     e_neg;
    logic signed [N_W-1:0]     e_pos;
    logic [STEP_W-1:0]         e_ln;
    logic                      e_shift;
    logic                      e_reject;
    logic signed [N_W:0]       e_sum;
    logic                      e_pass;
    logic [STEP_W-1:0]         k_lp;
    logic [STEP_W-1:0]         k_ln;
    logic signed [N_W-1:0]     k_pos;
    logic [STEP_W-1:0]         k_negc;
    logic signed [PROD_W-1:0]  k_left;
    logic                      k_pass;
    logic signed [CAND_W-1:0]  try_ext;
    logic                      cfg_wr;
    t_reg_idx                  cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= SCALE_RST;
            r_divisor <= DIVR_RST;
            r_coef1   <= COEF_RST;
            r_coef2   <= COEF_RST;
            r_step1   <= STEP_RST;
            r_step2   <= STEP_RST;
            r_offset  <= OFS_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCALE:   r_scale   <= pwdata[SCALE_W-1:0];
                REG_DIVISOR: r_divisor <= pwdata[DIVR_W-1:0];
                REG_COEF1:   r_coef1   <= pwdata[COEF_W-1:0];
                REG_COEF2:   r_coef2   <= pwdata[COEF_W-1:0];
                REG_STEP1:   r_step1   <= pwdata[STEP_W-1:0];
                REG_STEP2:   r_step2   <= pwdata[STEP_W-1:0];
                REG_OFFSET:  r_offset  <= pwdata[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SCALE:   prdata = DATA_W'(r_scale);
            REG_DIVISOR: prdata = DATA_W'(r_divisor);
            REG_COEF1:   prdata = DATA_W'($unsigned(r_coef1));
            REG_COEF2:   prdata = DATA_W'($unsigned(r_coef2));
            REG_STEP1:   prdata = DATA_W'(r_step1);
            REG_STEP2:   prdata = DATA_W'(r_step2);
            REG_OFFSET:  prdata = DATA_W'(r_offset);
            default:     prdata = '0;
        endcase
    end

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign a_in     = A_W'(i_in.adc_sample) + A_W'(r_offset);
    assign g_num    = NUM_W'(r_prod[NUM_W-1:0]) + NUM_W'(r_den >> 1);

    // candidate evaluation: which count is negative and must be lifted
    assign n1_neg   = r_n1[N_W-1];
    assign n2_neg   = r_n2[N_W-1];
    assign e_swap   = !n1_neg && n2_neg;
    assign e_neg    = e_swap ? r_n2 : r_n1;
    assign e_pos    = e_swap ? r_n1 : r_n2;
    assign e_ln     = e_swap ? r_step2 : r_step1;
    assign e_shift  = n1_neg || n2_neg;
    assign e_reject = (e_ln == '0) || e_pos[N_W-1];
    assign e_sum    = (N_W+1)'(r_n1) + (N_W+1)'(r_n2);
    assign e_pass   = e_sum < (N_W+1)'(COUNT_LIMIT);

    assign k_lp     = r_swap ? r_step1 : r_step2;
    assign k_ln     = r_swap ? r_step2 : r_step1;
    assign k_pos    = r_swap ? r_n1 : r_n2;
    assign k_negc   = k_ln - STEP_W'(1) - div_rem[STEP_W-1:0];
    assign k_left   = PROD_W'(k_pos) - r_prod;
    assign k_pass   = !k_left[PROD_W-1] && (k_left < PROD_W'(r_lim));

    assign try_ext  = CAND_W'(r_try);

    always_comb begin
        case (r_state)
            S_DEN: begin
                mul_a = MA_W'(r_divisor);
                mul_b = MB_W'(r_a);
            end
            S_NUM: begin
                mul_a = MA_W'(r_rest);
                mul_b = MB_W'(r_scale);
            end
            S_MUL1: begin
                mul_a = MA_W'(r_coef1);
                mul_b = MB_W'(r_cand);
            end
            S_MUL2: begin
                mul_a = MA_W'(r_coef2);
                mul_b = MB_W'(r_cand);
            end
            S_KMUL: begin
                mul_a = MA_W'(k_lp);
                mul_b = MB_W'(r_k);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = DIV_W'(g_num);
        div_divisor  = r_den;
        case (r_state)
            S_IDLE:   if (in_fire) n_state = S_DEN;
            S_DEN:    n_state = S_NUM;
            S_NUM:    n_state = S_GSTART;
            S_GSTART: begin
                if (r_den == '0) begin
                    n_state = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_GDIV;
                end
            end
            S_GDIV:   if (div_done) n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_EVAL;
            S_EVAL: begin
                // lift the negative count by ceil(need / step): divide need-1
                div_dividend = ~e_neg[DIV_W-1:0];
                div_divisor  = DEN_W'(e_ln);
                if (e_shift) begin
                    if (e_reject) begin
                        n_state = S_NEXT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_KDIV;
                    end
                end else begin
                    n_state = e_pass ? S_DONE : S_NEXT;
                end
            end
            S_KDIV:   if (div_done) n_state = S_KMUL;
            S_KMUL:   n_state = S_KCHK;
            S_KCHK:   n_state = k_pass ? S_DONE : S_NEXT;
            S_NEXT:   n_state = (r_try == TRY_W'(MAX_TRIES)) ? S_IDLE : S_MUL1;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a    <= a_in;
                r_rest <= (a_in > A_W'(FULL_SCALE)) ? '0
                                                    : REST_W'(A_W'(FULL_SCALE) - a_in);
            end
            S_DEN:  r_den  <= mul_p[DEN_W-1:0];
            S_NUM:  r_prod <= mul_p;
            S_GDIV: begin
                r_cand <= CAND_W'(div_quo[NUM_W-1:0]);
                r_try  <= TRY_W'(1);
            end
            S_MUL1: r_n1 <= mul_p[N_W-1:0];
            S_MUL2: r_n2 <= mul_p[N_W-1:0];
            S_EVAL: begin
                r_swap <= e_swap;
                r_res1 <= r_n1[COUNT_W-1:0];
                r_res2 <= r_n2[COUNT_W-1:0];
            end
            S_KDIV: r_k <= div_quo + DIV_W'(1);
            S_KMUL: begin
                r_prod <= mul_p;
                r_negc <= k_negc;
                r_lim  <= LIM_W'(COUNT_LIMIT) - LIM_W'(k_negc);
            end
            S_KCHK: begin
                r_res1 <= r_swap ? k_left[COUNT_W-1:0] : r_negc[COUNT_W-1:0];
                r_res2 <= r_swap ? r_negc[COUNT_W-1:0] : k_left[COUNT_W-1:0];
            end
            S_NEXT: begin
                // walk outward: +1, -2, +3, -4, ...
                r_cand <= r_try[0] ? r_cand + try_ext : r_cand - try_ext;
                r_try  <= r_try + TRY_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_first  <= r_res1;
            r_out_second <= r_res2;
        end
    end

    prcs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.count_first  = r_out_first;
    assign o_out.count_second = r_out_second;

endmodule
